>>> design/cpfa_pkg.sv
// Shared types, constants and helpers for the contiguous page frame allocator.
package cpfa_pkg;

  localparam int FRAMES     = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 32;

  localparam int IDX_W   = $clog2(FRAMES);
  localparam int LIM_W   = $clog2(FRAMES + 1);
  localparam int CNT_W   = 11;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RUN_CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;
  localparam int IDXF_W  = ADDR_BITS - PAGE_SHIFT;
  localparam int FCMP_W  = (IDXF_W > LIM_W) ? IDXF_W : LIM_W;
  localparam int FRAME_BITS = 2;

  localparam logic [CNT_W-1:0] PM_RESET = CNT_W'(1024);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NORUN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_MANAGED = CFG_IDX_W'(1);

  localparam logic [1:0] RK_ALLOC_OK = 2'd0;
  localparam logic [1:0] RK_FREE_OK  = 2'd1;
  localparam logic [1:0] RK_NORUN    = 2'd2;
  localparam logic [1:0] RK_RANGE    = 2'd3;

  typedef struct packed {
    logic             op;
    logic [CNT_W-1:0] page_count;
    logic [31:0]      address;
  } cpfa_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      phys_address;
    logic [CNT_W-1:0] pages_freed;
  } cpfa_rsp_t;

  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       scan_init;
    logic       scan_step;
    logic       write_step;
    logic       diff_step;
    logic       walk_init;
    logic       walk_step;
    logic       finish;
    logic [1:0] kind;
  } cpfa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic want_bad;
    logic scan_found;
    logic scan_exhausted;
    logic write_last;
    logic free_bad;
    logic walk_done;
  } cpfa_sts_t;

  function automatic logic [LIM_W-1:0] managed_limit(input logic [CNT_W-1:0] pm);
    logic [RUN_CMP_W-1:0] p;
    p = RUN_CMP_W'(pm);
    if (p > RUN_CMP_W'(FRAMES)) begin
      return LIM_W'(FRAMES);
    end
    return LIM_W'(p);
  endfunction

endpackage

>>> design/cpfa_ram.sv
// Generic simple dual-port RAM with registered read.
module cpfa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cpfa_ctrl.sv
// Sequencing state machine for clear, allocate and free.
module cpfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  cpfa_pkg::cpfa_sts_t sts,
  output cpfa_pkg::cpfa_cmd_t cmd,
  output logic                busy
);
  import cpfa_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ACHK  = 4'd2;
  localparam logic [3:0] S_ASCAN = 4'd3;
  localparam logic [3:0] S_AWR   = 4'd4;
  localparam logic [3:0] S_FPREP = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FWALK = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (op == OP_ALLOC) ? S_ACHK : S_FPREP;
        end
      end
      S_ACHK: begin
        if (sts.want_bad) begin
          cmd.finish = 1'b1;
          cmd.kind   = RK_NORUN;
          state_next = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_found) begin
          state_next = S_AWR;
        end else if (sts.scan_exhausted) begin
          cmd.finish = 1'b1;
          cmd.kind   = RK_NORUN;
          state_next = S_IDLE;
        end
      end
      S_AWR: begin
        cmd.write_step = 1'b1;
        if (sts.write_last) begin
          cmd.finish = 1'b1;
          cmd.kind   = RK_ALLOC_OK;
          state_next = S_IDLE;
        end
      end
      S_FPREP: begin
        cmd.diff_step = 1'b1;
        state_next    = S_FCHK;
      end
      S_FCHK: begin
        if (sts.free_bad) begin
          cmd.finish = 1'b1;
          cmd.kind   = RK_RANGE;
          state_next = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_FWALK;
        end
      end
      S_FWALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) begin
          cmd.finish = 1'b1;
          cmd.kind   = RK_FREE_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/cpfa_datapath.sv
// Frame map RAM, scan/walk pointers, config registers and result register.
module cpfa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cpfa_pkg::cpfa_req_t                 req,
  input  logic                                cfg_we,
  input  logic [cpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpfa_pkg::DATA_W-1:0]         cfg_data,
  input  cpfa_pkg::cpfa_cmd_t                 cmd,
  output cpfa_pkg::cpfa_sts_t                 sts,
  output logic                                done,
  output cpfa_pkg::cpfa_rsp_t                 rsp
);
  import cpfa_pkg::*;

  logic [31:0]           base;
  logic [CNT_W-1:0]      pm;
  logic [LIM_W-1:0]      limit;

  logic [CNT_W-1:0]      want;
  logic [31:0]           addr_r;
  logic [ADDR_BITS-1:0]  diff;
  logic                  borrow;

  logic [LIM_W-1:0]      ptr;
  logic [LIM_W-1:0]      ptr_next;
  logic [LIM_W-1:0]      dptr;
  logic                  dvalid;
  logic [LIM_W-1:0]      run;
  logic [LIM_W-1:0]      run_next;
  logic [IDX_W-1:0]      start_idx;
  logic [IDX_W-1:0]      start_next;
  logic [IDX_W-1:0]      end_idx;
  logic [LIM_W-1:0]      nfreed;
  logic [LIM_W-1:0]      nfreed_next;

  logic                  issue;
  logic                  in_use;
  logic                  chained;
  logic                  found;
  logic [IDXF_W-1:0]     fidx;
  logic [ADDR_BITS-1:0]  addr_ext;
  logic [ADDR_BITS-1:0]  base_ext;
  logic [ADDR_BITS-1:0]  alloc_sum;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [FRAME_BITS-1:0] ram_wdata;
  logic [FRAME_BITS-1:0] ram_rdata;

  cpfa_ram #(
    .WIDTH(FRAME_BITS),
    .DEPTH(FRAMES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      pm   <= PM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_BASE:   base <= cfg_data[31:0];
        CFG_PAGES_MANAGED: pm   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit    = managed_limit(pm);
  assign in_use   = ram_rdata[1];
  assign chained  = ram_rdata[0];
  assign addr_ext = ADDR_BITS'(addr_r);
  assign base_ext = ADDR_BITS'(base);
  assign fidx     = diff[ADDR_BITS-1:PAGE_SHIFT];
  assign alloc_sum = base_ext + (ADDR_BITS'(start_idx) << PAGE_SHIFT);

  assign issue       = (cmd.scan_step || cmd.walk_step) && (ptr < limit);
  assign run_next    = in_use ? '0 : run + LIM_W'(1);
  assign start_next  = (run == '0) ? dptr[IDX_W-1:0] : start_idx;
  assign found       = cmd.scan_step && dvalid && !in_use &&
                       (RUN_CMP_W'(run_next) == RUN_CMP_W'(want));
  assign nfreed_next = nfreed + LIM_W'(1);

  always_comb begin
    sts.clear_last     = (ptr == LIM_W'(FRAMES - 1));
    sts.want_bad       = (want == '0) || (RUN_CMP_W'(want) > RUN_CMP_W'(limit));
    sts.scan_found     = found;
    sts.scan_exhausted = !dvalid && (ptr >= limit);
    sts.write_last     = (ptr[IDX_W-1:0] == end_idx);
    sts.free_bad       = borrow || (FCMP_W'(fidx) >= FCMP_W'(limit));
    sts.walk_done      = dvalid && (!chained || ((dptr + LIM_W'(1)) == limit));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[IDX_W-1:0];
    ram_wdata = '0;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.write_step) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, ptr[IDX_W-1:0] != end_idx};
    end else if (cmd.walk_step && dvalid) begin
      ram_we    = 1'b1;
      ram_waddr = dptr[IDX_W-1:0];
    end
  end

  always_comb begin
    ptr_next = ptr;
    if (cmd.clear_step || cmd.write_step || issue) begin
      ptr_next = ptr + LIM_W'(1);
    end
    if (cmd.scan_init) begin
      ptr_next = '0;
    end else if (cmd.walk_init) begin
      ptr_next = LIM_W'(fidx);
    end else if (found) begin
      ptr_next = LIM_W'(start_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      dvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      ptr    <= ptr_next;
      dvalid <= issue;
      done   <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    dptr <= ptr;
    if (cmd.load) begin
      want   <= req.page_count;
      addr_r <= req.address;
    end
    if (cmd.diff_step) begin
      diff   <= addr_ext - base_ext;
      borrow <= addr_ext < base_ext;
    end
    if (cmd.scan_init) begin
      run <= '0;
    end else if (cmd.scan_step && dvalid) begin
      run       <= run_next;
      start_idx <= start_next;
    end
    if (found) begin
      end_idx <= dptr[IDX_W-1:0];
    end
    if (cmd.walk_init) begin
      nfreed <= '0;
    end else if (cmd.walk_step && dvalid) begin
      nfreed <= nfreed_next;
    end
    if (cmd.finish) begin
      case (cmd.kind)
        RK_ALLOC_OK: begin
          rsp.status       <= ST_OK;
          rsp.phys_address <= 32'(alloc_sum);
          rsp.pages_freed  <= '0;
        end
        RK_FREE_OK: begin
          rsp.status       <= ST_OK;
          rsp.phys_address <= '0;
          rsp.pages_freed  <= CNT_W'(nfreed_next);
        end
        RK_NORUN: begin
          rsp.status       <= ST_NORUN;
          rsp.phys_address <= '0;
          rsp.pages_freed  <= '0;
        end
        default: begin
          rsp.status       <= ST_RANGE;
          rsp.phys_address <= '0;
          rsp.pages_freed  <= '0;
        end
      endcase
    end
  end

endmodule

>>> design/contiguous_page_frame_allocator_core.sv
// Top level of the first-fit contiguous page frame allocator.
//
// Requests: start/busy command channel; a request transfers at a clock edge
// with start high and busy low. op selects allocate or free.
// Results: one per request, shown on rsp for exactly one cycle with done high.
// The receiver cannot stall; done arrives only while busy is low.
// Config: cfg_valid/cfg_ready write channel, cfg_index 0 region_base,
// 1 pages_managed; cfg_ready is always high. Write only while idle.
// Sequencing: an allocate runs a first-fit scan of the L managed frames,
// reading one map entry per cycle from the frame map RAM, and then writes
// one entry per cycle for the N frames granted. A free walks its run of K
// frames, one map entry a cycle. A failed request returns without writing
// the map; an allocate that finds no run fails once its scan is exhausted.
// Throughput: one request at a time; the next start is taken in the cycle
// done is high at the earliest.
// Reset: synchronous rst clears config to region_base 0 and pages_managed
// 1024, then a clearing pass writes every map entry with busy high;
// requests are taken after it ends.
module contiguous_page_frame_allocator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  cpfa_pkg::cpfa_req_t            req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpfa_pkg::DATA_W-1:0]    cfg_data,
  output logic                           done,
  output cpfa_pkg::cpfa_rsp_t            rsp
);
  import cpfa_pkg::*;

  cpfa_cmd_t cmd;
  cpfa_sts_t sts;

  assign cfg_ready = 1'b1;

  cpfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (req.op),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  cpfa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

>>> design/cpfa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
module cpfa_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input cpfa_pkg::cpfa_rsp_t rsp
);
  import cpfa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but core not busy next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_NORUN || rsp.status == ST_RANGE))
    else $error("illegal status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.phys_address == '0 && rsp.pages_freed == '0))
    else $error("failed result carries data");

endmodule

bind contiguous_page_frame_allocator_core cpfa_checker u_cpfa_checker (.*);
